// ===== hdl/assert_macros.svh =====
// Assertion helpers. Each macro expects i_clk in the module that uses it; CTBM_ASSERT also expects i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CTBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every clock edge, reset cycles included.
`define CTBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

// ===== hdl/ctbm_pkg.sv =====
package ctbm_pkg;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int PAGE_W = 4;
    localparam int BANK_W = 4;
    localparam int OFF_W  = 10;
    localparam int DATA_W = 8;
    localparam int ADDR_W = 17;
    localparam int KIND_W = 2;

    localparam int TSD_DEFAULT = 1024;

    // Access opcodes.
    localparam logic [OP_W-1:0] OP_CPU_WR = 2'd0;
    localparam logic [OP_W-1:0] OP_PPU_RD = 2'd1;
    localparam logic [OP_W-1:0] OP_PPU_WR = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ZERO = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PASS = 2'd3;

    // Address decode constants.
    localparam logic [PAGE_W-1:0] PAGE_TOGGLE_LO = 4'd8;
    localparam logic [PAGE_W-1:0] PAGE_TOGGLE_HI = 4'd14;
    localparam logic [BANK_W-1:0] BANK_NT_HI     = 4'd14;
    localparam logic [BANK_W-1:0] BANK_TILE_WR   = 4'd9;
    localparam logic [OFF_W-1:0]  NT_ATTR_OFF    = 10'h3C0;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_TOGGLE,
        CLS_PATTERN,
        CLS_LATCH,
        CLS_PASS
    } t_cls;

    // One classified word handed from the front part to the back part.
    typedef struct packed {
        t_cls              cls;
        logic [2:0]        bank;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] tile;
    } t_work;

endpackage

// ===== hdl/ctbm_if.sv =====
interface ctbm_item_if;
    import ctbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [PAGE_W-1:0] cpu_page;
    logic [BANK_W-1:0] ppu_bank;
    logic [OFF_W-1:0]  ppu_offset;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, opcode, cpu_page, ppu_bank, ppu_offset, write_data,
                    input ready);
    modport sink (input valid, opcode, cpu_page, ppu_bank, ppu_offset, write_data,
                  output ready);
endinterface

interface ctbm_result_if;
    import ctbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] access_kind;
    logic [ADDR_W-1:0] chr_address;
    logic              program_bank;
    logic [DATA_W-1:0] tile_latch;

    modport source (output valid, access_kind, chr_address, program_bank, tile_latch,
                    input ready);
    modport sink (input valid, access_kind, chr_address, program_bank, tile_latch,
                  output ready);
endinterface

interface ctbm_cfg_if;
    logic valid;
    logic ready;
    logic variant;

    modport source (output valid, variant, input ready);
    modport sink (input valid, variant, output ready);
endinterface

// ===== hdl/ctbm_ram.sv =====
module ctbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read, writes leave it alone.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ctbm_front.sv =====
`include "assert_macros.svh"

module ctbm_front import ctbm_pkg::*; #(
    parameter int TILE_STORE_DEPTH = TSD_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctbm_item_if.sink    i_item,
    output t_work        o_work,
    output logic         o_work_valid,
    input  logic         i_work_ready
);

    localparam int AW = $clog2(TILE_STORE_DEPTH);

    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;
    logic            r_s1_valid;
    t_cls            r_s1_cls;
    logic [2:0]      r_s1_bank;
    logic [OFF_W-1:0] r_s1_off;

    logic            accept;
    t_cls            cls;
    logic            tile_wr;
    logic            ram_en;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign i_item.ready = !r_clearing && (!r_s1_valid || i_work_ready);
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        cls     = CLS_NONE;
        tile_wr = 1'b0;
        unique case (i_item.opcode)
            OP_CPU_WR: begin
                if (i_item.cpu_page >= PAGE_TOGGLE_LO && i_item.cpu_page <= PAGE_TOGGLE_HI) begin
                    cls = CLS_TOGGLE;
                end
            end
            OP_PPU_RD: begin
                if (!i_item.ppu_bank[BANK_W-1]) begin
                    cls = CLS_PATTERN;
                end else if (i_item.ppu_bank <= BANK_NT_HI
                             && i_item.ppu_offset < NT_ATTR_OFF) begin
                    cls = CLS_LATCH;
                end else begin
                    cls = CLS_PASS;
                end
            end
            OP_PPU_WR: begin
                tile_wr = (i_item.ppu_bank == BANK_TILE_WR);
            end
            default: begin
            end
        endcase
    end

    // After reset the store is swept to zero, one entry a cycle.
    assign ram_en    = r_clearing || (accept && (tile_wr || cls == CLS_LATCH));
    assign ram_we    = r_clearing || (accept && tile_wr);
    assign ram_addr  = r_clearing ? r_clr_addr : i_item.ppu_offset[AW-1:0];
    assign ram_wdata = r_clearing ? '0 : i_item.write_data;

    ctbm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TILE_STORE_DEPTH)
    ) u_tile_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(TILE_STORE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_work_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cls  <= cls;
            r_s1_bank <= i_item.ppu_bank[2:0];
            r_s1_off  <= i_item.ppu_offset;
        end
    end

    // The tile byte comes straight from the store's read register.
    assign o_work.cls    = r_s1_cls;
    assign o_work.bank   = r_s1_bank;
    assign o_work.offset = r_s1_off;
    assign o_work.tile   = ram_rdata;
    assign o_work_valid  = r_s1_valid;

    `CTBM_ASSERT_ALWAYS(a_reset_starts_clear, !i_rst_n |=> r_clearing, "clear pass not started")
    `CTBM_ASSERT(a_no_accept_in_clear, r_clearing |-> !accept, "item accepted during clear")

endmodule

// ===== hdl/ctbm_queue.sv =====
`include "assert_macros.svh"

module ctbm_queue import ctbm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_work i_work,
    input  logic  i_valid,
    output logic  o_ready,
    output t_work o_work,
    output logic  o_valid,
    input  logic  i_ready
);

    localparam int QDEPTH = 2;
    localparam int PW     = $clog2(QDEPTH);

    t_work           r_slot [QDEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [PW:0]     r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != (PW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_slot[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_work;
        end
    end

    `CTBM_ASSERT(a_count_bound, r_count <= (PW+1)'(QDEPTH), "queue count overflow")

endmodule

// ===== hdl/ctbm_back.sv =====
`include "assert_macros.svh"

module ctbm_back import ctbm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_work        i_work,
    input  logic         i_valid,
    output logic         o_ready,
    ctbm_cfg_if.sink     i_cfg,
    ctbm_result_if.source o_result
);

    logic              r_variant;
    logic              r_bank_bit;
    logic [DATA_W-1:0] r_latched;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic              r_prog;
    logic [DATA_W-1:0] r_tile;

    logic              pop;
    logic              n_bank_bit;
    logic [DATA_W-1:0] n_latched;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic              plane_hit;
    logic [DATA_W-1:0] t;
    logic [2:0]        b;
    logic [OFF_W-1:0]  a;

    assign i_cfg.ready = 1'b1;
    assign o_ready     = !r_out_valid || o_result.ready;
    assign pop         = i_valid && o_ready;

    assign t = r_latched;
    assign b = i_work.bank;
    assign a = i_work.offset;
    // The gated layout picks the plane by offset bit 3 against the tile's top bits.
    assign plane_hit = (!a[3] && t[7]) || (a[3] && t[6]);

    always_comb begin
        n_bank_bit = r_bank_bit;
        n_latched  = r_latched;
        kind       = KIND_NONE;
        addr       = '0;
        unique case (i_work.cls)
            CLS_TOGGLE: n_bank_bit = ~r_bank_bit;
            CLS_LATCH: begin
                n_latched = i_work.tile;
                kind      = KIND_PASS;
            end
            CLS_PASS: kind = KIND_PASS;
            CLS_PATTERN: begin
                kind = KIND_ROM;
                priority if (!r_variant && !r_bank_bit) begin
                    addr = {a[3], 4'b0000, b, a[9:4], a[2:0]};
                end else if (!r_variant) begin
                    addr = {t[5:0], b[1:0], a[9:4], a[2:0]};
                end else if (!r_bank_bit || t[7:6] == 2'b00) begin
                    addr = {4'b0000, b, a};
                end else if (plane_hit) begin
                    addr = {t[4:0], b[1:0], a[9:4], t[5], a[2:0]};
                end else begin
                    kind = KIND_ZERO;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant   <= 1'b0;
            r_bank_bit  <= 1'b1;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_variant <= i_cfg.variant;
            end
            if (pop) begin
                r_bank_bit  <= n_bank_bit;
                r_latched   <= n_latched;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind <= kind;
            r_addr <= addr;
            r_prog <= n_bank_bit;
            r_tile <= n_latched;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.access_kind  = r_kind;
    assign o_result.chr_address  = r_addr;
    assign o_result.program_bank = r_prog;
    assign o_result.tile_latch   = r_tile;

    `CTBM_ASSERT(a_toggle_flips, (pop && i_work.cls == CLS_TOGGLE) |=> (r_bank_bit != $past(r_bank_bit)), "bank bit did not flip")
    `CTBM_ASSERT(a_addr_only_rom, (r_out_valid && r_kind != KIND_ROM) |-> (r_addr == '0), "address on non-ROM word")

endmodule

// ===== hdl/cartridge_tile_bank_chr_mapper.sv =====
// Path: an accepted access word passes through the front stage register, a queue slot and
// the result register.
// Throughput: one access per cycle unless stalled, through the tile store's single port.
// Reset: synchronous, active low. Bank bit 1, latched tile 0, variant 0.
// After reset the 1 KB tile store (TILE_STORE_DEPTH entries) is swept to zero, during which
// no access is accepted; configuration writes are taken throughout.
module cartridge_tile_bank_chr_mapper import ctbm_pkg::*; #(
    parameter int TILE_STORE_DEPTH = TSD_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctbm_item_if.sink     i_item,
    ctbm_cfg_if.sink      i_cfg,
    ctbm_result_if.source o_result
);

    t_work front_work;
    logic  front_valid;
    logic  front_ready;
    t_work queue_work;
    logic  queue_valid;
    logic  back_ready;

    ctbm_front #(
        .TILE_STORE_DEPTH (TILE_STORE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_work       (front_work),
        .o_work_valid (front_valid),
        .i_work_ready (front_ready)
    );

    ctbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (front_work),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_work  (queue_work),
        .o_valid (queue_valid),
        .i_ready (back_ready)
    );

    ctbm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (queue_work),
        .i_valid  (queue_valid),
        .o_ready  (back_ready),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule
